/* sv/utf8r_pkg.sv */
// Shared types, constants and lead-byte decode for the UTF-8 character reassembler.
`timescale 1ns / 1ps

package utf8r_pkg;

    // Item field widths
    localparam int unsigned ByteW  = 8;
    // Work buffer holds the held bytes plus one arriving byte
    localparam int unsigned WorkN  = 4;
    localparam int unsigned CountW = 3;   // holds 0..WorkN
    localparam int unsigned IdxW   = 2;   // indexes 0..WorkN-1

    // Operation codes carried on s_tuser
    localparam logic OpData  = 1'b0;
    localparam logic OpFlush = 1'b1;

    // Byte class masks and patterns
    localparam logic [7:0] AsciiMask = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Pat  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Pat  = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Pat  = 8'hF0;
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContPat   = 8'h80;

    // Datapath commands from the controller
    typedef struct packed {
        logic load;       // append the input byte to the work buffer
        logic shift;      // remove the front byte of the work buffer
        logic push;       // copy the front byte into the output buffer
        logic emit_adv;   // step to the next output byte
        logic emit_done;  // empty the output buffer
    } utf8r_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic [CountW-1:0] work_count;  // bytes in the work buffer
        logic [CountW-1:0] lead_len;    // length led by the front byte, 0 if none
        logic              cont_ok;     // continuation bytes of that length are valid
        logic              out_any;     // output buffer holds at least one byte
        logic              out_last;    // output pointer is on the final byte
    } utf8r_stat_t;

    // Sequence length given by a lead byte, 0 if it cannot lead
    function automatic logic [CountW-1:0] lead_length(input logic [7:0] c);
        logic [CountW-1:0] len;
        len = '0;
        if ((c & AsciiMask) == 8'h00) begin
            len = CountW'(1);
        end else if ((c & Lead2Mask) == Lead2Pat) begin
            len = CountW'(2);
        end else if ((c & Lead3Mask) == Lead3Pat) begin
            len = CountW'(3);
        end else if ((c & Lead4Mask) == Lead4Pat) begin
            len = CountW'(4);
        end
        return len;
    endfunction

endpackage

/* sv/utf8r_dp.sv */
// Datapath: work buffer, output buffer and their counters.
`timescale 1ns / 1ps

module utf8r_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             in_byte,
    input  utf8r_pkg::utf8r_cmd_t  cmd,
    output utf8r_pkg::utf8r_stat_t stat,
    output logic [7:0]             out_byte
);
    import utf8r_pkg::*;

    logic [ByteW-1:0]  work_reg [WorkN];
    logic [ByteW-1:0]  work_next [WorkN];
    logic [CountW-1:0] wcnt_reg, wcnt_next;
    logic [ByteW-1:0]  obuf_reg [WorkN];
    logic [ByteW-1:0]  obuf_next [WorkN];
    logic [CountW-1:0] ocnt_reg, ocnt_next;
    logic [IdxW-1:0]   optr_reg, optr_next;
    logic [CountW-1:0] len;
    logic              cont_ok;

    // Decode the front byte and check the bytes that follow it
    always_comb begin
        len     = lead_length(work_reg[0]);
        cont_ok = 1'b1;
        for (int j = 1; j < WorkN; j++) begin
            if (CountW'(j) < len && (work_reg[j] & ContMask) != ContPat) begin
                cont_ok = 1'b0;
            end
        end
    end

    assign stat.work_count = wcnt_reg;
    assign stat.lead_len   = len;
    assign stat.cont_ok    = cont_ok;
    assign stat.out_any    = (ocnt_reg != '0);
    assign stat.out_last   = ({1'b0, optr_reg} == ocnt_reg - CountW'(1));
    assign out_byte        = obuf_reg[optr_reg];

    // Apply the controller's commands
    always_comb begin
        work_next = work_reg;
        wcnt_next = wcnt_reg;
        obuf_next = obuf_reg;
        ocnt_next = ocnt_reg;
        optr_next = optr_reg;
        if (cmd.load) begin
            work_next[wcnt_reg[IdxW-1:0]] = in_byte;
            wcnt_next = wcnt_reg + CountW'(1);
        end
        if (cmd.push) begin
            obuf_next[ocnt_reg[IdxW-1:0]] = work_reg[0];
            ocnt_next = ocnt_reg + CountW'(1);
        end
        if (cmd.shift) begin
            for (int k = 0; k < WorkN - 1; k++) begin
                work_next[k] = work_reg[k+1];
            end
            wcnt_next = wcnt_reg - CountW'(1);
        end
        if (cmd.emit_adv) begin
            optr_next = optr_reg + IdxW'(1);
        end
        if (cmd.emit_done) begin
            ocnt_next = '0;
            optr_next = '0;
        end
    end

    // Counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
            ocnt_reg <= '0;
            optr_reg <= '0;
        end else begin
            wcnt_reg <= wcnt_next;
            ocnt_reg <= ocnt_next;
            optr_reg <= optr_next;
        end
    end

    // Byte storage
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        obuf_reg <= obuf_next;
    end

endmodule

/* sv/utf8r_ctrl.sv */
// Controller: sequences load, scan, copy and emit of one item.
`timescale 1ns / 1ps

module utf8r_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_op,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  utf8r_pkg::utf8r_stat_t stat,
    output utf8r_pkg::utf8r_cmd_t  cmd
);
    import utf8r_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COPY,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CountW-1:0] copy_reg, copy_next;
    logic              scan_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);

    // Scan stops when the buffer is empty or its front sequence is unfinished
    assign scan_end = (stat.work_count == '0) ||
                      (stat.lead_len != '0 && stat.lead_len > stat.work_count);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        copy_next  = copy_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == OpFlush) begin
                        // Release all held bytes unchanged
                        if (stat.work_count != '0) begin
                            copy_next  = stat.work_count;
                            state_next = ST_COPY;
                        end
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = stat.out_any ? ST_EMIT : ST_IDLE;
                end else if (stat.lead_len == '0 || !stat.cont_ok) begin
                    // Drop a bad lead and rescan from the next byte
                    cmd.shift = 1'b1;
                end else begin
                    copy_next  = stat.lead_len;
                    state_next = ST_COPY;
                end
            end
            ST_COPY: begin
                cmd.push  = 1'b1;
                cmd.shift = 1'b1;
                copy_next = copy_reg - CountW'(1);
                if (copy_reg == CountW'(1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (stat.out_last) begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.emit_adv = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            copy_reg  <= '0;
        end else begin
            state_reg <= state_next;
            copy_reg  <= copy_next;
        end
    end

endmodule

/* sv/utf8_char_reassembler_core.sv */
// Top level of the UTF-8 character reassembler.
//
// Takes one item per handshake: a data byte (s_tuser = 0) or a flush (s_tuser = 1), and
// passes on only whole UTF-8 characters, one byte per output item, with m_tlast on the
// final byte released by each input item. Up to three bytes of an unfinished sequence
// are held between items. Stray continuation bytes and 0xF8..0xFF are dropped; when a
// complete-length sequence has a bad continuation byte only its lead is dropped and the
// bytes after it are scanned again. A flush releases the held bytes unchanged. An item
// is accepted while the controller is idle, then the controller scans each examined
// position and copies each released byte, then offers the output bytes one by one
// while m_tready is high; the next item is taken after the last output byte. The single
// controller walks the four-byte work buffer one byte per cycle. An empty flush is
// absorbed in its accept cycle.
`timescale 1ns / 1ps

module utf8_char_reassembler_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tuser,    // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast     // last_of_run
);
    import utf8r_pkg::*;

    utf8r_cmd_t  cmd;
    utf8r_stat_t stat;

    utf8r_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    utf8r_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_byte (m_tdata)
    );

    // Final byte of the run for this item
    assign m_tlast = stat.out_last;

endmodule

/* sv/utf8r_checker.sv */
// Port-level checker for the UTF-8 character reassembler, bound to the top level.
`timescale 1ns / 1ps

module utf8r_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import utf8r_pkg::*;

    // No output item right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Input side is closed while results are offered
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // A data item always starts a scan
    a_data_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OpData) |=> !s_tready)
        else $error("ready right after a data item");

    // The run ends with its last item
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output valid after last item of run");

    // Hold a stalled output item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output item changed");

endmodule

bind utf8_char_reassembler_core utf8r_checker u_utf8r_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
